FILE: rtl/core/fbpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-size block pool allocator.
package fbpa_pkg;

  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int SIZE_W   = 13;
  localparam int OFS_W    = 22;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b1;

  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 11'd1024;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 13'd8;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_MIN  = 13'd8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] block_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [OFS_W-1:0] byte_offset;
    logic [CNT_W-1:0] used_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read;
    logic exec;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/fbpa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing one allocate or free word at a time.
module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output fbpa_pkg::dp_cmd_t   dp_cmd,
  input  fbpa_pkg::dp_status_t dp_sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    dp_cmd.load = 1'b0;
    dp_cmd.read = 1'b0;
    dp_cmd.exec = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        // Fetch the link of the current free-list head.
        dp_cmd.read = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (dp_sts.out_free) begin
          dp_cmd.exec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_READ))
    else $error("accepted word did not start a link fetch");
  a_read_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EXEC))
    else $error("link fetch not followed by execution");
  a_exec_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.exec |-> dp_sts.out_free)
    else $error("execution issued while the output register is occupied");
`endif

endmodule

FILE: rtl/core/fbpa_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration, free-list state, link store and result register.
module fbpa_dp #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbpa_pkg::in_word_t                  in_data,
  output fbpa_pkg::out_word_t                 out_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fbpa_pkg::dp_cmd_t                   dp_cmd,
  output fbpa_pkg::dp_status_t                dp_sts
);

  // Indices are ten bits wide, so the link store never needs more entries than that.
  localparam int MEM_DEPTH = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam int IDX_W  = fbpa_pkg::IDX_W;
  localparam int CNT_W  = fbpa_pkg::CNT_W;
  localparam int SIZE_W = fbpa_pkg::SIZE_W;
  localparam int OFS_W  = fbpa_pkg::OFS_W;
  localparam int PROD_W = CNT_W + SIZE_W;

  logic [IDX_W-1:0] link_mem [MEM_DEPTH];
  logic [IDX_W-1:0] link_rd_r;

  logic [CNT_W-1:0]  block_count_r;
  logic [SIZE_W-1:0] block_size_r;

  fbpa_pkg::in_word_t  item_r;
  fbpa_pkg::out_word_t out_word_r, out_word_nxt;
  logic                out_valid_r;

  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0] watermark_r, watermark_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;

  logic [CNT_W-1:0]  eff_count;
  logic [SIZE_W-1:0] eff_size;
  logic [CNT_W-1:0]  used_inc;
  logic [CNT_W-1:0]  grant;
  logic              link_we;
  logic [PROD_W-1:0] prod;
  logic [1:0]        status;

  assign eff_count = ({21'd0, block_count_r} > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : block_count_r;
  assign eff_size  = (block_size_r < fbpa_pkg::BLOCK_SIZE_MIN) ? fbpa_pkg::BLOCK_SIZE_MIN
                                                             : block_size_r;
  assign used_inc  = used_r + CNT_W'(1);

  always_comb begin
    free_head_nxt = free_head_r;
    nonempty_nxt  = nonempty_r;
    watermark_nxt = watermark_r;
    used_nxt      = used_r;
    grant         = '0;
    status        = fbpa_pkg::ST_OK;
    link_we       = 1'b0;
    if (item_r.cmd == fbpa_pkg::CMD_ALLOC) begin
      if (used_r >= eff_count) begin
        status = fbpa_pkg::ST_EXHAUSTED;
      end else if (nonempty_r) begin
        grant         = {1'b0, free_head_r};
        free_head_nxt = link_rd_r;
        used_nxt      = used_inc;
        nonempty_nxt  = watermark_r > used_inc;
      end else if (watermark_r < eff_count) begin
        grant         = watermark_r;
        watermark_nxt = watermark_r + CNT_W'(1);
        used_nxt      = used_inc;
      end else begin
        status = fbpa_pkg::ST_EXHAUSTED;
      end
    end else begin
      if ({1'b0, item_r.block_index} >= eff_count) begin
        status = fbpa_pkg::ST_RANGE;
      end else if (used_r == '0) begin
        status = fbpa_pkg::ST_NONE;
      end else begin
        link_we       = 1'b1;
        free_head_nxt = item_r.block_index;
        nonempty_nxt  = 1'b1;
        used_nxt      = used_r - CNT_W'(1);
      end
    end
  end

  assign prod = {{SIZE_W{1'b0}}, grant} * {{CNT_W{1'b0}}, eff_size};

  always_comb begin
    out_word_nxt.status        = status;
    out_word_nxt.granted_index = grant[IDX_W-1:0];
    out_word_nxt.byte_offset   = prod[OFS_W-1:0];
    out_word_nxt.used_count    = used_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= fbpa_pkg::BLOCK_COUNT_RST;
      block_size_r  <= fbpa_pkg::BLOCK_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbpa_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data[CNT_W-1:0];
        fbpa_pkg::CFG_BLOCK_SIZE:  block_size_r  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Free-list control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      nonempty_r  <= 1'b0;
      watermark_r <= '0;
      used_r      <= '0;
    end else if (dp_cmd.exec) begin
      free_head_r <= free_head_nxt;
      nonempty_r  <= nonempty_nxt;
      watermark_r <= watermark_nxt;
      used_r      <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      item_r <= in_data;
    end
  end

  // Link store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && link_we) begin
      link_mem[item_r.block_index[AW-1:0]] <= free_head_r;
    end
    if (dp_cmd.read) begin
      link_rd_r <= link_mem[free_head_r[AW-1:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign dp_sts.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_word_r;

`ifndef SYNTHESIS
  a_list_matches_counts: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r == (watermark_r > used_r))
    else $error("free-list flag disagrees with watermark and use count");
  a_used_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= watermark_r)
    else $error("more blocks in use than ever handed out");
  a_exec_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.exec |=> out_valid_r)
    else $error("executed word produced no result");
`endif

endmodule

FILE: rtl/core/fixed_block_pool_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the fixed-size block pool allocator.
//
//   channel  direction  handshake              word
//   in_      input      in_valid / in_stall    cmd, block_index
//   out_     output     out_valid / out_stall  status, granted_index, byte_offset, used_count
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each word is worked in order: accept, registered link store read of the free-list
// head, then execute into the output register. The registered read port is why the read step is needed.
// Reset (synchronous, active low) clears the pool counters and restores the configuration
// defaults; the link store is not cleared, as only entries already pushed are ever used.
// A stalled result is held while the next word is accepted and worked up to execution.
module fixed_block_pool_allocator_top #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fbpa_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fbpa_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  fbpa_pkg::dp_cmd_t    dp_cmd;
  fbpa_pkg::dp_status_t dp_sts;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts)
  );

  fbpa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

endmodule
